@@ rtl/core/rsh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared types, widths and coefficient tables of the harmonics core.
// ----------------------------------------------------------------------------
package rsh_pkg;

   localparam int DEG_W    = 3;
   localparam int ADDR_W   = 2 * DEG_W;
   localparam int LEG_DEPTH = 1 << ADDR_W;
   localparam int COORD_W  = 16;
   localparam int VAL_W    = 34;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int R2_W     = 32;
   localparam int SREM_W   = 32;
   localparam int ROOT_W   = 30;
   localparam int DREM_W   = 30;
   localparam int QUO_W    = 29;
   localparam int STEP_W   = 5;
   localparam int COEF_W   = 19;
   localparam int ORD_W    = 4;
   localparam int FRAC     = 28;
   localparam int OUT_SH   = 40;
   localparam int COEF_MAX = 262143;
   localparam int COEF_MIN = -262144;
   localparam int SQRT_STEPS = 30;
   localparam int DIV_STEPS  = QUO_W;
   localparam int OPD_COUNT  = 14;

   localparam logic signed [VAL_W-1:0] ONE_Q28      = VAL_W'(268435456);
   localparam logic signed [VAL_W-1:0] INV_SQRT_4PI = VAL_W'(75724244);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQR, ST_SQRT, ST_DIV, ST_TRIG, ST_LEG_DIAG, ST_LEG_COL,
      ST_OUT, ST_DRAIN
   } state_type;

   typedef enum logic [3:0] {
      OPD_ZERO, OPD_X, OPD_Y, OPD_Z, OPD_UX, OPD_UY, OPD_UZ, OPD_CPW, OPD_SPW,
      OPD_PREV1, OPD_PREV2, OPD_DIAG, OPD_TMP, OPD_CONST
   } opd_type;

   typedef enum logic [1:0] {CST_A, CST_B, CST_D} cst_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_ACC_LOAD, WB_ACC_ADD, WB_R2, WB_CPW, WB_SPW, WB_TMP,
      WB_TMP_SUB, WB_DIAG_INIT, WB_DIAG, WB_LEG
   } wb_type;

   typedef struct packed {
      logic                    load;
      opd_type                 a_sel;
      opd_type                 b_sel;
      cst_type                 cst_sel;
      wb_type                  wb;
      logic                    sqrt_step;
      logic                    div_init;
      logic                    div_step;
      logic                    div_store;
      logic [1:0]              comp;
      logic                    out_issue;
      logic [DEG_W-1:0]        deg;
      logic [DEG_W-1:0]        col;
      logic signed [ORD_W-1:0] ord;
      logic                    last;
   } dp_cmd_type;

   typedef logic [7:0][7:0][31:0] tab_type;

   localparam int TAB_A = 0;
   localparam int TAB_B = 1;
   localparam int TAB_D = 2;

   // round half away from zero, shift right by sh
   function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] p,
                                                      input int unsigned sh);
      logic [ACC_W-1:0] mag;
      mag = p[ACC_W-1] ? ACC_W'(-p) : ACC_W'(p);
      mag = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
      return p[ACC_W-1] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bw;
      v   = v_in;
      res = '0;
      bw  = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bw > v) bw = bw >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bw != 0) begin
            if (v >= res + bw) begin
               v   = v - (res + bw);
               res = (res >> 1) + bw;
            end else begin
               res = res >> 1;
            end
            bw = bw >> 2;
         end
      end
      return res;
   endfunction

   // shift-subtract long division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [31:0] root_ratio(input int n, input int d);
      logic [63:0] num;
      num = 64'(n) << 56;
      return 32'(isqrt64(udiv64(num, 64'(d))));
   endfunction

   function automatic tab_type build_tab(input int kind);
      tab_type t;
      t = '0;
      for (int l = 0; l < 8; l++) begin
         for (int m = 0; m < 8; m++) begin
            if (kind == TAB_A && m < l) begin
               if (l == m + 1) t[l][m] = root_ratio(2 * m + 3, 1);
               else t[l][m] = root_ratio(4 * l * l - 1, l * l - m * m);
            end else if (kind == TAB_B && m + 1 < l) begin
               t[l][m] = root_ratio((l - 1) * (l - 1) - m * m, 4 * (l - 1) * (l - 1) - 1);
            end else if (kind == TAB_D && l == m && m >= 1) begin
               if (m == 1) t[l][m] = root_ratio(3, 1);
               else t[l][m] = root_ratio(2 * m + 1, 2 * m);
            end
         end
      end
      return t;
   endfunction

   localparam tab_type A_TAB = build_tab(TAB_A);
   localparam tab_type B_TAB = build_tab(TAB_B);
   localparam tab_type D_TAB = build_tab(TAB_D);

endpackage
`default_nettype wire

@@ rtl/core/real_spherical_harmonics_eval_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// real_spherical_harmonics_eval_core
// Real spherical harmonics up to the programmed degree for one direction.
//
//   channel  ports                       handshake
//   request  req_coord_x/y/z             start & !busy
//   result   rsp_*                       rsp_valid, one cycle each
//   csr      csr_wr_data (degree_max)    csr_wr_en
//
// One request at a time; busy drops in the cycle that carries its last result.
// After acceptance: squaring, a 30-step root and three 29-step divides,
// then trig powers, the Legendre diagonal and columns, and the output
// phase through the output pipeline registers.
// All products share one 34x34 multiplier. Sync reset clears control only.
// Results cannot be stalled; each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module real_spherical_harmonics_eval_core import rsh_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [COORD_W-1:0] req_coord_x,
   input  wire logic signed [COORD_W-1:0] req_coord_y,
   input  wire logic signed [COORD_W-1:0] req_coord_z,
   input  wire logic                      csr_wr_en,
   input  wire logic [DEG_W-1:0]          csr_wr_data,
   output logic                           rsp_valid,
   output logic signed [COEF_W-1:0]       rsp_coefficient,
   output logic        [DEG_W-1:0]        rsp_degree,
   output logic signed [ORD_W-1:0]        rsp_order,
   output logic                           rsp_last,
   output logic                           rsp_zero_vector
);

   dp_cmd_type cmd;

   rsh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd)
   );

   rsh_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .rsp_valid      (rsp_valid),
      .rsp_coefficient(rsp_coefficient),
      .rsp_degree     (rsp_degree),
      .rsp_order      (rsp_order),
      .rsp_last       (rsp_last),
      .rsp_zero_vector(rsp_zero_vector)
   );

endmodule
`default_nettype wire

@@ rtl/core/rsh_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/rsh_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_ctrl
// Sequencer: holds the degree register and steps the datapath through
// squaring, root, division, trig powers, Legendre diagonal and columns and output.
// ----------------------------------------------------------------------------
module rsh_ctrl import rsh_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [DEG_W-1:0] csr_wr_data,
   input  wire logic             start,
   output logic                  busy,
   output dp_cmd_type            cmd
);

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [1:0]              comp_ff, comp_in;
   logic [DEG_W-1:0]        m_ff, m_in;
   logic [DEG_W-1:0]        l_ff, l_in;
   logic signed [ORD_W-1:0] ord_ff, ord_in;
   logic [DEG_W-1:0]        lmax_ff, lmax_in;
   logic [DEG_W-1:0]        degree_max_ff;
   logic                    ord_at_l;
   logic                    is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         degree_max_ff <= DEG_W'(3);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) degree_max_ff <= csr_wr_data;
      end
      step_ff <= step_in;
      comp_ff <= comp_in;
      m_ff    <= m_in;
      l_ff    <= l_in;
      ord_ff  <= ord_in;
      lmax_ff <= lmax_in;
   end

   assign busy     = (state_ff != ST_IDLE);
   assign ord_at_l = (ord_ff == $signed({1'b0, l_ff}));
   assign is_last  = (l_ff == lmax_ff) && ord_at_l;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + STEP_W'(1);
      comp_in  = comp_ff;
      m_in     = m_ff;
      l_in     = l_ff;
      ord_in   = ord_ff;
      lmax_in  = lmax_ff;
      cmd      = '0;
      cmd.comp = comp_ff;
      cmd.deg  = l_ff;
      cmd.col  = m_ff;
      cmd.ord  = ord_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               lmax_in  = degree_max_ff;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            case (step_ff)
               5'd0: begin
                  cmd.a_sel = OPD_X;
                  cmd.b_sel = OPD_X;
               end
               5'd1: begin
                  cmd.a_sel = OPD_Y;
                  cmd.b_sel = OPD_Y;
                  cmd.wb    = WB_ACC_LOAD;
               end
               5'd2: begin
                  cmd.a_sel = OPD_Z;
                  cmd.b_sel = OPD_Z;
                  cmd.wb    = WB_ACC_ADD;
               end
               default: begin
                  cmd.wb   = WB_R2;
                  step_in  = '0;
                  state_in = ST_SQRT;
               end
            endcase
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               comp_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               cmd.div_init = 1'b1;
            end else if (step_ff == STEP_W'(DIV_STEPS + 1)) begin
               cmd.div_store = 1'b1;
               step_in       = '0;
               if (comp_ff == 2'd2) begin
                  if (lmax_ff == '0) begin
                     m_in     = '0;
                     state_in = ST_LEG_DIAG;
                  end else begin
                     m_in     = DEG_W'(1);
                     state_in = ST_TRIG;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_TRIG: begin
            case (step_ff)
               5'd0: begin
                  cmd.a_sel = OPD_CPW;
                  cmd.b_sel = OPD_UX;
               end
               5'd1: begin
                  cmd.a_sel = OPD_SPW;
                  cmd.b_sel = OPD_UY;
                  cmd.wb    = WB_ACC_LOAD;
               end
               5'd2: begin
                  cmd.a_sel = OPD_CPW;
                  cmd.b_sel = OPD_UY;
                  cmd.wb    = WB_CPW;
               end
               5'd3: begin
                  cmd.a_sel = OPD_SPW;
                  cmd.b_sel = OPD_UX;
                  cmd.wb    = WB_ACC_LOAD;
               end
               default: begin
                  cmd.wb  = WB_SPW;
                  step_in = '0;
                  if (m_ff == lmax_ff) begin
                     m_in     = '0;
                     state_in = ST_LEG_DIAG;
                  end else begin
                     m_in = m_ff + DEG_W'(1);
                  end
               end
            endcase
         end
         ST_LEG_DIAG: begin
            cmd.deg = m_ff;
            if (m_ff != '0 && step_ff == '0) begin
               cmd.a_sel   = OPD_DIAG;
               cmd.b_sel   = OPD_CONST;
               cmd.cst_sel = CST_D;
            end else begin
               cmd.wb  = (m_ff == '0) ? WB_DIAG_INIT : WB_DIAG;
               step_in = '0;
               if (m_ff == lmax_ff) begin
                  l_in     = '0;
                  ord_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  l_in     = m_ff + DEG_W'(1);
                  state_in = ST_LEG_COL;
               end
            end
         end
         ST_LEG_COL: begin
            case (step_ff)
               5'd0: begin
                  cmd.a_sel = OPD_UZ;
                  cmd.b_sel = OPD_PREV1;
               end
               5'd1: begin
                  cmd.a_sel   = OPD_CONST;
                  cmd.cst_sel = CST_B;
                  cmd.b_sel   = OPD_PREV2;
                  cmd.wb      = WB_TMP;
               end
               5'd2: begin
                  cmd.wb = WB_TMP_SUB;
               end
               5'd3: begin
                  cmd.a_sel   = OPD_CONST;
                  cmd.cst_sel = CST_A;
                  cmd.b_sel   = OPD_TMP;
               end
               default: begin
                  cmd.wb  = WB_LEG;
                  step_in = '0;
                  if (l_ff == lmax_ff) begin
                     m_in     = m_ff + DEG_W'(1);
                     state_in = ST_LEG_DIAG;
                  end else begin
                     l_in = l_ff + DEG_W'(1);
                  end
               end
            endcase
         end
         ST_OUT: begin
            cmd.out_issue = 1'b1;
            cmd.last      = is_last;
            step_in       = '0;
            if (is_last) begin
               state_in = ST_DRAIN;
            end else if (ord_at_l) begin
               l_in   = l_ff + DEG_W'(1);
               ord_in = $signed(ORD_W'(0) - ORD_W'({1'b0, l_ff}) - ORD_W'(2)) + 4'sd1;
            end else begin
               ord_in = ord_ff + 4'sd1;
            end
         end
         ST_DRAIN: begin
            if (step_ff == 5'd1) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/rsh_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_datapath
// Shared multiplier with round/accumulate write-back, bit-serial root and
// divider, trig power registers, Legendre store and output pipeline.
// ----------------------------------------------------------------------------
module rsh_datapath import rsh_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dp_cmd_type                 cmd,
   input  wire logic signed [COORD_W-1:0]  req_coord_x,
   input  wire logic signed [COORD_W-1:0]  req_coord_y,
   input  wire logic signed [COORD_W-1:0]  req_coord_z,
   output logic                            rsp_valid,
   output logic signed [COEF_W-1:0]        rsp_coefficient,
   output logic        [DEG_W-1:0]         rsp_degree,
   output logic signed [ORD_W-1:0]         rsp_order,
   output logic                            rsp_last,
   output logic                            rsp_zero_vector
);

   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic                      zero_ff;
   logic [R2_W-1:0]           rad_ff;
   logic [SREM_W-1:0]         srem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [DREM_W-1:0]         drem_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic                      neg_ff;
   logic signed [VAL_W-1:0]   ux_ff, uy_ff, uz_ff;
   logic signed [VAL_W-1:0]   cpw_ff [8];
   logic signed [VAL_W-1:0]   spw_ff [8];
   logic signed [VAL_W-1:0]   prev1_ff, prev2_ff, diag_ff, tmp_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [VAL_W-1:0]   trig_ff;

   logic                      v1_ff, v2_ff;
   logic [DEG_W-1:0]          l1_ff, l2_ff;
   logic signed [ORD_W-1:0]   o1_ff, o2_ff;
   logic                      last1_ff, last2_ff;

   logic signed [VAL_W-1:0]   opd_val [OPD_COUNT];
   logic signed [VAL_W-1:0]   cst_val;
   logic signed [VAL_W-1:0]   ma, mb;
   logic signed [ACC_W-1:0]   prod_x, sum_add, sum_sub, out_rnd;
   logic signed [VAL_W-1:0]   rp;
   logic signed [COORD_W-1:0] cval;
   logic [COORD_W-1:0]        cmag;
   logic [SREM_W+1:0]         srem2, strial;
   logic [DREM_W:0]           drem2, dsub;
   logic [ORD_W-1:0]          kneg;
   logic [DEG_W-1:0]          k;
   logic                      ram_we;
   logic [VAL_W-1:0]          ram_wdata, ram_rdata;
   logic signed [VAL_W-1:0]   uval;
   logic signed [COEF_W-1:0]  coef;

   always_comb begin
      case (cmd.cst_sel)
         CST_A:   cst_val = $signed({2'b00, A_TAB[cmd.deg][cmd.col]});
         CST_B:   cst_val = $signed({2'b00, B_TAB[cmd.deg][cmd.col]});
         CST_D:   cst_val = $signed({2'b00, D_TAB[cmd.col][cmd.col]});
         default: cst_val = '0;
      endcase
      opd_val[OPD_ZERO]  = '0;
      opd_val[OPD_X]     = VAL_W'(x_ff);
      opd_val[OPD_Y]     = VAL_W'(y_ff);
      opd_val[OPD_Z]     = VAL_W'(z_ff);
      opd_val[OPD_UX]    = ux_ff;
      opd_val[OPD_UY]    = uy_ff;
      opd_val[OPD_UZ]    = uz_ff;
      opd_val[OPD_CPW]   = cpw_ff[cmd.col - DEG_W'(1)];
      opd_val[OPD_SPW]   = spw_ff[cmd.col - DEG_W'(1)];
      opd_val[OPD_PREV1] = prev1_ff;
      opd_val[OPD_PREV2] = prev2_ff;
      opd_val[OPD_DIAG]  = diag_ff;
      opd_val[OPD_TMP]   = tmp_ff;
      opd_val[OPD_CONST] = cst_val;
   end

   assign ma      = v1_ff ? $signed(ram_rdata) : opd_val[cmd.a_sel];
   assign mb      = v1_ff ? trig_ff : opd_val[cmd.b_sel];
   assign prod_x  = ACC_W'(prod_ff);
   assign sum_add = acc_ff + prod_x;
   assign sum_sub = acc_ff - prod_x;
   assign rp      = VAL_W'(rnd_sh(prod_x, FRAC));

   assign cval = (cmd.comp == 2'd0) ? x_ff : ((cmd.comp == 2'd1) ? y_ff : z_ff);
   assign cmag = cval[COORD_W-1] ? (~cval + COORD_W'(1)) : cval;

   assign srem2  = {srem_ff, rad_ff[R2_W-1 -: 2]};
   assign strial = (SREM_W+2)'({root_ff, 2'b01});
   assign drem2  = {drem_ff, 1'b0};
   assign dsub   = {1'b0, root_ff};
   assign uval   = neg_ff ? -$signed(VAL_W'(quo_ff)) : $signed(VAL_W'(quo_ff));

   assign kneg = cmd.ord[ORD_W-1] ? (ORD_W'(0) - cmd.ord) : cmd.ord;
   assign k    = kneg[DEG_W-1:0];

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = rp;
      case (cmd.wb)
         WB_DIAG_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = INV_SQRT_4PI;
         end
         WB_DIAG: begin
            ram_we    = 1'b1;
            ram_wdata = -rp;
         end
         WB_LEG: begin
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   rsh_ram #(
      .WIDTH(VAL_W),
      .DEPTH(LEG_DEPTH)
   ) u_leg_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr({cmd.deg, cmd.col}),
      .wr_data(ram_wdata),
      .rd_addr({cmd.deg, k}),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
      if (cmd.load) begin
         x_ff      <= req_coord_x;
         y_ff      <= req_coord_y;
         z_ff      <= req_coord_z;
         cpw_ff[0] <= ONE_Q28;
         spw_ff[0] <= '0;
      end
      case (cmd.wb)
         WB_ACC_LOAD: acc_ff <= prod_x;
         WB_ACC_ADD:  acc_ff <= sum_add;
         WB_R2: begin
            zero_ff <= (sum_add[R2_W-1:0] == '0);
            rad_ff  <= sum_add[R2_W-1:0];
            srem_ff <= '0;
            root_ff <= '0;
         end
         WB_CPW:     cpw_ff[cmd.col] <= VAL_W'(rnd_sh(sum_sub, FRAC));
         WB_SPW:     spw_ff[cmd.col] <= VAL_W'(rnd_sh(sum_add, FRAC));
         WB_TMP:     tmp_ff <= rp;
         WB_TMP_SUB: tmp_ff <= tmp_ff - rp;
         WB_DIAG_INIT: begin
            diag_ff  <= INV_SQRT_4PI;
            prev1_ff <= INV_SQRT_4PI;
            prev2_ff <= '0;
         end
         WB_DIAG: begin
            diag_ff  <= -rp;
            prev1_ff <= -rp;
            prev2_ff <= '0;
         end
         WB_LEG: begin
            prev2_ff <= prev1_ff;
            prev1_ff <= rp;
         end
         default: begin
         end
      endcase
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[R2_W-3:0], 2'b00};
         if (srem2 >= strial) begin
            srem_ff <= SREM_W'(srem2 - strial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= SREM_W'(srem2);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.div_init) begin
         drem_ff <= DREM_W'({cmag, 13'b0});
         quo_ff  <= '0;
         neg_ff  <= cval[COORD_W-1];
      end
      if (cmd.div_step) begin
         if (drem2 >= dsub) begin
            drem_ff <= DREM_W'(drem2 - dsub);
            quo_ff  <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            drem_ff <= DREM_W'(drem2);
            quo_ff  <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
      if (cmd.div_store) begin
         case (cmd.comp)
            2'd0:    ux_ff <= zero_ff ? '0 : uval;
            2'd1:    uy_ff <= zero_ff ? '0 : uval;
            default: uz_ff <= zero_ff ? '0 : uval;
         endcase
      end
      trig_ff  <= cmd.ord[ORD_W-1] ? spw_ff[k] : cpw_ff[k];
      l1_ff    <= cmd.deg;
      o1_ff    <= cmd.ord;
      last1_ff <= cmd.last;
      l2_ff    <= l1_ff;
      o2_ff    <= o1_ff;
      last2_ff <= last1_ff;
   end

   assign out_rnd = rnd_sh(prod_x, OUT_SH);

   always_comb begin
      if (zero_ff) coef = '0;
      else if (out_rnd > ACC_W'(COEF_MAX)) coef = COEF_W'(COEF_MAX);
      else if (out_rnd < ACC_W'(COEF_MIN)) coef = COEF_W'(COEF_MIN);
      else coef = out_rnd[COEF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         v1_ff     <= cmd.out_issue;
         v2_ff     <= v1_ff;
         rsp_valid <= v2_ff;
      end
      rsp_coefficient <= coef;
      rsp_degree      <= l2_ff;
      rsp_order       <= o2_ff;
      rsp_last        <= last2_ff;
      rsp_zero_vector <= zero_ff;
   end

endmodule
`default_nettype wire
